/* rtl/cac_pkg.sv */
// cac_pkg: shared types, sizes and codes of the call arc counter
// depends on nothing; used by cac_store, cac_ctrl and call_arc_counter

package cac_pkg;

    // table sizes
    localparam int NUM_BUCKETS  = 1024;
    localparam int NUM_ARCS     = 1024;
    localparam int BUCKET_SHIFT = 2;
    localparam int BKT_W        = $clog2(NUM_BUCKETS);
    localparam int ARC_W        = $clog2(NUM_ARCS);

    // configuration register indexes
    localparam logic [1:0] REG_ENABLE    = 2'd0;
    localparam logic [1:0] REG_BASE_ADDR = 2'd1;
    localparam logic [1:0] REG_TEXT_SIZE = 2'd2;
    localparam logic [1:0] REG_ARC_LIMIT = 2'd3;

    // configuration reset values
    localparam logic [11:0] TEXT_SIZE_RST = 12'd4092;
    localparam logic [10:0] ARC_LIMIT_RST = 11'd1024;

    // commands
    localparam logic [1:0] CMD_RECORD  = 2'd0;
    localparam logic [1:0] CMD_RD_HEAD = 2'd1;
    localparam logic [1:0] CMD_RD_ARC  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_HEAD     = 3'd0;
    localparam logic [2:0] ST_MOVED    = 3'd1;
    localparam logic [2:0] ST_NEW      = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;
    localparam logic [2:0] ST_DISABLED = 3'd5;
    localparam logic [2:0] ST_READ     = 3'd6;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] caller_pc;
        logic [31:0] callee_pc;
        logic [9:0]  read_index;
    } cac_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  entry;
        logic [31:0] arc_callee;
        logic [31:0] arc_count;
    } cac_out_t;

    typedef struct packed {
        logic        enable;
        logic [31:0] base_addr;
        logic [11:0] text_size;
        logic [10:0] arc_limit;
        logic        halt_clear;
    } cac_cfg_t;

    // one access per table per cycle
    typedef struct packed {
        logic [BKT_W-1:0] head_addr;
        logic             head_we;
        logic [ARC_W-1:0] head_wdata;
        logic [ARC_W-1:0] ent_addr;
        logic             callee_we;
        logic [31:0]      callee_wdata;
        logic             count_we;
        logic [31:0]      count_wdata;
        logic [ARC_W-1:0] link_addr;
        logic             link_we;
        logic [ARC_W-1:0] link_wdata;
    } cac_mem_req_t;

    typedef struct packed {
        logic [ARC_W-1:0] head;
        logic [31:0]      callee;
        logic [31:0]      count;
        logic [ARC_W-1:0] link;
    } cac_mem_rsp_t;

endpackage

/* rtl/cac_store.sv */
// cac_store: bucket head table and arc entry tables, one port each
// depends on cac_pkg

module cac_store (
    input  logic                  clk,
    input  cac_pkg::cac_mem_req_t req,
    output cac_pkg::cac_mem_rsp_t rsp
);

    logic [cac_pkg::ARC_W-1:0] head_mem   [cac_pkg::NUM_BUCKETS];
    logic [31:0]               callee_mem [cac_pkg::NUM_ARCS];
    logic [31:0]               count_mem  [cac_pkg::NUM_ARCS];
    logic [cac_pkg::ARC_W-1:0] link_mem   [cac_pkg::NUM_ARCS];

    always_ff @(posedge clk)
    begin
        if (req.head_we)
        begin
            head_mem[req.head_addr] <= req.head_wdata;
        end
        if (req.callee_we)
        begin
            callee_mem[req.ent_addr] <= req.callee_wdata;
        end
        if (req.count_we)
        begin
            count_mem[req.ent_addr] <= req.count_wdata;
        end
        if (req.link_we)
        begin
            link_mem[req.link_addr] <= req.link_wdata;
        end
        rsp.head   <= head_mem[req.head_addr];
        rsp.callee <= callee_mem[req.ent_addr];
        rsp.count  <= count_mem[req.ent_addr];
        rsp.link   <= link_mem[req.link_addr];
    end

endmodule

/* rtl/cac_ctrl.sv */
// cac_ctrl: sequencer that walks a bucket chain one link per cycle
// with a shared callee compare and count increment; depends on cac_pkg

module cac_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cac_pkg::cac_cfg_t     cfg,
    input  logic                  req_valid,
    input  cac_pkg::cac_in_t      req,
    output logic                  ready,
    output logic                  emit_valid,
    output cac_pkg::cac_out_t     res,
    input  logic                  out_free,
    output cac_pkg::cac_mem_req_t mem_req,
    input  cac_pkg::cac_mem_rsp_t mem_rsp
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HEAD,
        S_RDH,
        S_RDE,
        S_ENT,
        S_MOVE,
        S_ALLOC,
        S_EMIT
    } state_t;

    state_t                    state_reg, state_next;
    logic [cac_pkg::BKT_W-1:0] clr_reg, clr_next;
    logic [31:0]               off_reg, off_next;
    logic [31:0]               callee_reg, callee_next;
    logic [cac_pkg::ARC_W-1:0] head_reg, head_next;
    logic [cac_pkg::ARC_W-1:0] cur_reg, cur_next;
    logic [cac_pkg::ARC_W-1:0] prev_reg, prev_next;
    logic                      first_reg, first_next;
    logic [10:0]               next_free_reg, next_free_next;
    logic                      halted_reg, halted_next;
    cac_pkg::cac_out_t         res_reg, res_next;

    logic [31:0]               off_calc;
    logic [cac_pkg::BKT_W-1:0] bucket;
    logic                      out_of_range;
    logic [cac_pkg::ARC_W-1:0] head_val;
    logic                      hit;
    logic [31:0]               cnt_inc;
    logic [10:0]               nf;
    logic [10:0]               lim;

    // shared datapath
    assign off_calc     = req.caller_pc - cfg.base_addr;
    assign bucket       = cac_pkg::BKT_W'(off_reg >> cac_pkg::BUCKET_SHIFT);
    assign out_of_range = (off_reg > 32'(cfg.text_size))
                          || ((off_reg >> cac_pkg::BUCKET_SHIFT) >= 32'(cac_pkg::NUM_BUCKETS));
    assign head_val     = ({1'b0, mem_rsp.head} >= 11'(cac_pkg::NUM_ARCS)) ? '0 : mem_rsp.head;
    assign hit          = (mem_rsp.callee == callee_reg);
    assign cnt_inc      = mem_rsp.count + 32'd1;
    assign nf           = next_free_reg + 11'd1;
    assign lim          = (cfg.arc_limit < 11'(cac_pkg::NUM_ARCS)) ? cfg.arc_limit
                                                                     : 11'(cac_pkg::NUM_ARCS);

    assign ready      = (state_reg == S_IDLE);
    assign emit_valid = (state_reg == S_EMIT);
    assign res        = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        off_next       = off_reg;
        callee_next    = callee_reg;
        head_next      = head_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        first_next     = first_reg;
        next_free_next = next_free_reg;
        halted_next    = halted_reg;
        res_next       = res_reg;
        mem_req        = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_req.head_addr = clr_reg;
                mem_req.head_we   = 1'b1;
                clr_next          = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    off_next    = off_calc;
                    callee_next = req.callee_pc;
                    cur_next    = cac_pkg::ARC_W'(req.read_index);
                    res_next    = '0;
                    case (req.cmd)
                        cac_pkg::CMD_RECORD:
                        begin
                            if (!cfg.enable)
                            begin
                                res_next.status = cac_pkg::ST_DISABLED;
                                state_next      = S_EMIT;
                            end
                            else if (halted_reg)
                            begin
                                res_next.status = cac_pkg::ST_OVERFLOW;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                mem_req.head_addr =
                                    cac_pkg::BKT_W'(off_calc >> cac_pkg::BUCKET_SHIFT);
                                state_next = S_HEAD;
                            end
                        end
                        cac_pkg::CMD_RD_HEAD:
                        begin
                            mem_req.head_addr = cac_pkg::BKT_W'(req.read_index);
                            state_next        = S_RDH;
                        end
                        cac_pkg::CMD_RD_ARC:
                        begin
                            mem_req.ent_addr  = cac_pkg::ARC_W'(req.read_index);
                            mem_req.link_addr = cac_pkg::ARC_W'(req.read_index);
                            state_next        = S_RDE;
                        end
                        default:
                        begin
                            res_next.status = cac_pkg::ST_DISABLED;
                            state_next      = S_EMIT;
                        end
                    endcase
                end
            end
            S_HEAD:
            begin
                if (out_of_range)
                begin
                    res_next.status = cac_pkg::ST_RANGE;
                    state_next      = S_EMIT;
                end
                else
                begin
                    head_next = head_val;
                    if (head_val == '0)
                    begin
                        state_next = S_ALLOC;
                    end
                    else
                    begin
                        mem_req.ent_addr  = head_val;
                        mem_req.link_addr = head_val;
                        cur_next          = head_val;
                        first_next        = 1'b1;
                        state_next        = S_ENT;
                    end
                end
            end
            S_RDH:
            begin
                res_next.status = cac_pkg::ST_READ;
                if ({1'b0, cur_reg} < 11'(cac_pkg::NUM_BUCKETS))
                begin
                    res_next.entry = 10'(mem_rsp.head);
                end
                state_next = S_EMIT;
            end
            S_RDE:
            begin
                res_next.status = cac_pkg::ST_READ;
                if ({1'b0, cur_reg} < 11'(cac_pkg::NUM_ARCS))
                begin
                    res_next.entry      = 10'(mem_rsp.link);
                    res_next.arc_callee = mem_rsp.callee;
                    res_next.arc_count  = mem_rsp.count;
                end
                state_next = S_EMIT;
            end
            S_ENT:
            begin
                if (hit)
                begin
                    mem_req.ent_addr    = cur_reg;
                    mem_req.count_we    = 1'b1;
                    mem_req.count_wdata = cnt_inc;
                    res_next.entry      = 10'(cur_reg);
                    res_next.arc_callee = callee_reg;
                    res_next.arc_count  = cnt_inc;
                    if (first_reg)
                    begin
                        res_next.status = cac_pkg::ST_HEAD;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        // unlink from predecessor and make it the bucket head
                        res_next.status    = cac_pkg::ST_MOVED;
                        mem_req.link_addr  = prev_reg;
                        mem_req.link_we    = 1'b1;
                        mem_req.link_wdata = mem_rsp.link;
                        mem_req.head_addr  = bucket;
                        mem_req.head_we    = 1'b1;
                        mem_req.head_wdata = cur_reg;
                        state_next         = S_MOVE;
                    end
                end
                else if ((mem_rsp.link == '0)
                         || ({1'b0, mem_rsp.link} >= 11'(cac_pkg::NUM_ARCS)))
                begin
                    state_next = S_ALLOC;
                end
                else
                begin
                    // follow the link; data arrives next cycle
                    mem_req.ent_addr  = mem_rsp.link;
                    mem_req.link_addr = mem_rsp.link;
                    prev_next         = cur_reg;
                    cur_next          = mem_rsp.link;
                    first_next        = 1'b0;
                end
            end
            S_MOVE:
            begin
                mem_req.link_addr  = cur_reg;
                mem_req.link_we    = 1'b1;
                mem_req.link_wdata = head_reg;
                state_next         = S_EMIT;
            end
            S_ALLOC:
            begin
                if (nf >= lim)
                begin
                    halted_next     = 1'b1;
                    res_next.status = cac_pkg::ST_OVERFLOW;
                end
                else
                begin
                    next_free_next       = nf;
                    mem_req.ent_addr     = cac_pkg::ARC_W'(nf);
                    mem_req.callee_we    = 1'b1;
                    mem_req.callee_wdata = callee_reg;
                    mem_req.count_we     = 1'b1;
                    mem_req.count_wdata  = 32'd1;
                    mem_req.link_addr    = cac_pkg::ARC_W'(nf);
                    mem_req.link_we      = 1'b1;
                    mem_req.link_wdata   = head_reg;
                    mem_req.head_addr    = bucket;
                    mem_req.head_we      = 1'b1;
                    mem_req.head_wdata   = cac_pkg::ARC_W'(nf);
                    res_next.status      = cac_pkg::ST_NEW;
                    res_next.entry       = 10'(nf);
                    res_next.arc_callee  = callee_reg;
                    res_next.arc_count   = 32'd1;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg.halt_clear)
        begin
            halted_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            off_reg       <= '0;
            callee_reg    <= '0;
            head_reg      <= '0;
            cur_reg       <= '0;
            prev_reg      <= '0;
            first_reg     <= 1'b0;
            next_free_reg <= '0;
            halted_reg    <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            off_reg       <= off_next;
            callee_reg    <= callee_next;
            head_reg      <= head_next;
            cur_reg       <= cur_next;
            prev_reg      <= prev_next;
            first_reg     <= first_next;
            next_free_reg <= next_free_next;
            halted_reg    <= halted_next;
            res_reg       <= res_next;
        end
    end

    // halt only comes from a failed allocation
    a_halt_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(halted_reg) |-> $past(state_reg) == S_ALLOC)
        else $error("halt flag set outside allocation");

    // allocation never runs past the table
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_free_reg < 11'(cac_pkg::NUM_ARCS))
        else $error("free index beyond arc table");

    // chain walk never visits the null entry
    a_walk_nonnull: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ENT |-> cur_reg != '0)
        else $error("chain walk on null entry");

    // move-to-front is always finished right after a hit down the chain
    a_move_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MOVE |=> state_reg == S_EMIT && res_reg.status == cac_pkg::ST_MOVED)
        else $error("move-to-front sequence broken");

    // a fresh arc always reports a count of one
    a_new_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && res_reg.status == cac_pkg::ST_NEW) |-> res_reg.arc_count == 32'd1)
        else $error("new arc with count other than one");

endmodule

/* rtl/call_arc_counter.sv */
// call_arc_counter: top level of the call-graph arc counter
// depends on cac_pkg, cac_store and cac_ctrl
//
// usage
//   req channel: one transaction per command (record call, read bucket head,
//     read arc entry); accepted when req_valid is high and req_stall is low
//   rsp channel: exactly one transaction per command, in order, accepted when
//     rsp_valid is high and rsp_stall is low
//   cfg port: write enable, register index and data; writes land at once and
//     are done by the user only while no command is in flight (not enforced)
// command sequence
//   one command at a time; a record reads its bucket head, then checks the
//   head entry on a hit or allocates for an empty bucket, then emits; each
//   link walked past the head adds a step, as do a move to the front and an
//   allocation after a walk; reads and out of range records go from lookup
//   to emit, refused records from idle to emit; the next command is taken in idle
// reset
//   after rst_n rises the bucket head table is cleared one bucket per cycle,
//   all 1024 buckets, during which req_stall stays high; cfg writes still land
// stall
//   a result sits in the output register while rsp_stall is high; the next
//   command may be accepted meanwhile and waits in the sequencer until the
//   output register frees up

module call_arc_counter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  cac_pkg::cac_in_t  req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output cac_pkg::cac_out_t rsp,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_wdata
);

    // configuration registers
    logic        enable_reg;
    logic [31:0] base_addr_reg;
    logic [11:0] text_size_reg;
    logic [10:0] arc_limit_reg;

    // output register
    logic              rsp_valid_reg;
    cac_pkg::cac_out_t rsp_reg;

    cac_pkg::cac_cfg_t     cfg;
    cac_pkg::cac_mem_req_t mem_req;
    cac_pkg::cac_mem_rsp_t mem_rsp;
    cac_pkg::cac_out_t     res;
    logic                  ready;
    logic                  emit_valid;
    logic                  out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            base_addr_reg <= '0;
            text_size_reg <= cac_pkg::TEXT_SIZE_RST;
            arc_limit_reg <= cac_pkg::ARC_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cac_pkg::REG_ENABLE:    enable_reg    <= cfg_wdata[0];
                cac_pkg::REG_BASE_ADDR: base_addr_reg <= cfg_wdata;
                cac_pkg::REG_TEXT_SIZE: text_size_reg <= cfg_wdata[11:0];
                cac_pkg::REG_ARC_LIMIT: arc_limit_reg <= cfg_wdata[10:0];
            endcase
        end
    end

    // any write of enable also re-arms recording after an overflow
    always_comb
    begin
        cfg.enable     = enable_reg;
        cfg.base_addr  = base_addr_reg;
        cfg.text_size  = text_size_reg;
        cfg.arc_limit  = arc_limit_reg;
        cfg.halt_clear = cfg_we && (cfg_index == cac_pkg::REG_ENABLE);
    end

    cac_store u_store (
        .clk (clk),
        .req (mem_req),
        .rsp (mem_rsp)
    );

    cac_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .req_valid  (req_valid),
        .req        (req),
        .ready      (ready),
        .emit_valid (emit_valid),
        .res        (res),
        .out_free   (out_free),
        .mem_req    (mem_req),
        .mem_rsp    (mem_rsp)
    );

    // output slot is free when empty or being drained this cycle
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else if (emit_valid && out_free)
        begin
            rsp_valid_reg <= 1'b1;
            rsp_reg       <= res;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
